>>> rtl/fas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fas_pkg: shared constants and types for the truncating single-precision adder
// Holds field widths and the leading-one search used by the normalize stage.
// ----------------------------------------------------------------------------
package fas_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    // significand with hidden bit and one guard bit
    localparam int unsigned MantW = FracW + 2;
    // magnitude sum may carry one bit further
    localparam int unsigned SumW  = MantW + 1;
    // signed exponent wide enough for bias shifts and normalization
    localparam int unsigned EW    = ExpW + 3;
    localparam int unsigned AlignLimit = 26;

    typedef logic signed [EW-1:0] t_exp;
    typedef logic [SumW-1:0]      t_sum;

    // Position of the highest set bit (0 for zero input).
    function automatic logic [4:0] top_bit(input t_sum m);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < SumW; i++) begin
            if (m[i]) p = 5'(i);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

>>> rtl/float32_add_sub_truncating.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float32_add_sub_truncating: pipelined single-precision add/subtract
// Truncating, no special values; flags an exponent outside 0..255.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries op, a, b on i_valid / o_ready. op = 0 adds,
//   op = 1 subtracts b from a. Output channel carries o_result and
//   o_exp_range_flag on o_valid / i_ready.
//   Four register stages: unpack and compare, align, add or subtract,
//   normalize and pack. An accepted word moves through them in that order
//   to o_valid, held in place while the stage ahead cannot advance.
//   One word per cycle sustained; a new word every clock unless stalled.
//   When the receiver holds i_ready low the final stage keeps its word; a
//   full earlier stage stalls only while the one ahead cannot advance, and
//   o_ready falls only while every stage is full and the last is untaken.
//   Synchronous active-low reset clears all stage valid bits; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module float32_add_sub_truncating (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result,
    output logic             o_exp_range_flag
);
    import fas_pkg::*;

    // stage valid bits and per-stage advance
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !r_v4 || i_ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    // stage 1: unpack, pick larger exponent
    logic             r1_agb;
    t_exp             r1_e;
    logic [ExpW:0]    r1_d;
    logic [MantW-1:0] r1_mbig, r1_msml;
    logic             r1_sbig, r1_ssml;

    logic [ExpW-1:0]  n_ea, n_eb;
    logic [MantW-1:0] n_ma, n_mb;
    logic             n_agb;
    assign n_ea  = i_a[30:23];
    assign n_eb  = i_b[30:23];
    assign n_ma  = {1'b1, i_a[22:0], 1'b0};
    assign n_mb  = {1'b1, i_b[22:0], 1'b0};
    assign n_agb = n_ea > n_eb;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_agb  <= n_agb;
            r1_e    <= t_exp'({1'b0, (n_agb ? n_ea : n_eb)}) - t_exp'(1);
            r1_d    <= n_agb ? ({1'b0, n_ea} - {1'b0, n_eb}) : ({1'b0, n_eb} - {1'b0, n_ea});
            r1_mbig <= n_agb ? n_ma : n_mb;
            r1_msml <= n_agb ? n_mb : n_ma;
            r1_sbig <= n_agb ? i_a[31] : i_b[31] ^ i_op;
            r1_ssml <= n_agb ? i_b[31] ^ i_op : i_a[31];
        end
    end

    // stage 2: align the smaller operand, truncating
    logic [MantW-1:0] r2_big, r2_sml;
    logic             r2_sbig, r2_ssml, r2_abig;
    t_exp             r2_e;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_big  <= r1_mbig;
            r2_sml  <= (r1_d >= (ExpW+1)'(AlignLimit)) ? '0 : (r1_msml >> r1_d);
            r2_sbig <= r1_sbig;
            r2_ssml <= r1_ssml;
            r2_abig <= r1_agb;
            r2_e    <= r1_e;
        end
    end

    // stage 3: add or subtract magnitudes
    t_sum r3_m;
    logic r3_s;
    t_exp r3_e;
    logic n3_sml_gt;
    assign n3_sml_gt = r2_sml > r2_big;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_e <= r2_e;
            if (r2_sbig != r2_ssml) begin
                // ties go to the b side, as the larger-of test is strict
                if (n3_sml_gt || (r2_sml == r2_big && r2_abig)) begin
                    r3_m <= t_sum'(r2_sml) - t_sum'(r2_big);
                    r3_s <= r2_ssml;
                end else begin
                    r3_m <= t_sum'(r2_big) - t_sum'(r2_sml);
                    r3_s <= r2_sbig;
                end
            end else begin
                r3_m <= t_sum'(r2_big) + t_sum'(r2_sml);
                r3_s <= r2_sbig;
            end
        end
    end

    // stage 4: normalize leading one to bit 23 and pack
    logic [4:0] n4_p;
    t_sum       n4_m;
    t_exp       n4_e;
    assign n4_p = top_bit(r3_m);
    always_comb begin
        if (n4_p > 5'd23) begin
            n4_m = r3_m >> (n4_p - 5'd23);
            n4_e = r3_e + t_exp'(n4_p - 5'd23);
        end else begin
            n4_m = r3_m << (5'd23 - n4_p);
            n4_e = r3_e - t_exp'(5'd23 - n4_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            if (r3_m == '0) begin
                o_result         <= '0;
                o_exp_range_flag <= 1'b0;
            end else begin
                o_result         <= {r3_s, n4_e[ExpW-1:0], n4_m[FracW-1:0]};
                o_exp_range_flag <= (n4_e < 0) || (n4_e > t_exp'(255));
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end
    assign o_valid = r_v4;

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("output word changed under stall");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && r_v4 && !i_ready)
        else $error("input stalled with room in pipeline");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif
endmodule
`default_nettype wire

>>> verif/float32_add_sub_truncating_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Checker for the truncating single-precision adder
// Watches both channels, predicts each sum or difference from the operands,
// and compares every result word with the oldest prediction in order.
// ----------------------------------------------------------------------------
module float32_add_sub_truncating_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic        i_op,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_result,
    input  wire logic        i_exp_range_flag,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] result;
        logic        flag;
    } t_sum_word;

    t_sum_word pending_sums[$];

    // Predict one sum or difference, truncating at every step
    function automatic t_sum_word predict_sum(input logic op, input logic [31:0] a,
                                              input logic [31:0] b);
        t_sum_word w;
        logic      sa, sb, s;
        int        ea, eb, e, d, p;
        logic [31:0] ma, mb, m;
        sa = a[31];
        sb = b[31] ^ op;
        ea = int'(a[30:23]) - 1;
        eb = int'(b[30:23]) - 1;
        ma = {8'd0, 1'b1, a[22:0]} << 1;
        mb = {8'd0, 1'b1, b[22:0]} << 1;
        if (ea > eb) begin
            d = ea - eb;
            mb = (d >= 26) ? 32'd0 : (mb >> d);
            e = ea;
        end else begin
            d = eb - ea;
            ma = (d >= 26) ? 32'd0 : (ma >> d);
            e = eb;
        end
        if (sa != sb) begin
            if (ma > mb) begin
                m = ma - mb;
                s = sa;
            end else begin
                m = mb - ma;
                s = sb;
            end
        end else begin
            m = ma + mb;
            s = sa;
        end
        w = '0;
        if (m == 0) return w;
        p = 0;
        for (int i = 0; i < 32; i++) if (m[i]) p = i;
        if (p > 23) begin
            m = m >> (p - 23);
            e = e + (p - 23);
        end else if (p < 23) begin
            m = m << (23 - p);
            e = e - (23 - p);
        end
        w.result = {s, e[7:0], m[22:0]};
        w.flag = (e < 0) || (e > 255);
        return w;
    endfunction

    assign o_pending = pending_sums.size();

    // Record input words and check output words at each edge
    always @(posedge i_clk) begin
        t_sum_word want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_ready_in) pending_sums.push_back(predict_sum(i_op, i_a, i_b));
            if (i_out_valid && i_out_ready) begin
                if (pending_sums.size() == 0) begin
                    $display("%0t: unexpected word result=%h flag=%b", $time,
                             i_result, i_exp_range_flag);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_sums.pop_front();
                    if (want.result !== i_result || want.flag !== i_exp_range_flag) begin
                        $display("%0t: mismatch expected result=%h flag=%b actual result=%h flag=%b",
                                 $time, want.result, want.flag, i_result, i_exp_range_flag);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/float32_add_sub_truncating_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the truncating single-precision adder
// Drives directed corner operands then random ones with random gaps and
// stalls, including a long output hold-off; the checker grades every word.
// ----------------------------------------------------------------------------
module float32_add_sub_truncating_tb;

    localparam logic OpAdd = 1'b0;
    localparam logic OpSub = 1'b1;
    localparam int   RandomWords = 700;
    localparam int   CycleLimit = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_op = 1'b0;
    logic [31:0] i_a = '0;
    logic [31:0] i_b = '0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_exp_range_flag;
    logic [31:0] o_result;
    int          fail_count, pending;
    int          cycles = 0;
    bit          hold_long = 1'b0;

    float32_add_sub_truncating dut (.*);

    float32_add_sub_truncating_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_op(i_op), .i_a(i_a), .i_b(i_b), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_result(o_result),
        .i_exp_range_flag(o_exp_range_flag), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    // Abort on a runaway run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one word after a random gap, hold until taken
    task automatic send_word(input logic op, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_a <= a;
        i_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Build an operand with random sign and fraction, exponent 0, 255 or 100..160
    function automatic logic [31:0] rand_operand();
        logic [7:0] e;
        case ($urandom_range(0, 5))
            0: e = 8'd0;
            1: e = 8'd255;
            default: e = 8'($urandom_range(100, 160));
        endcase
        return {1'($urandom), e, 23'($urandom)};
    endfunction

    // Receiver: random stalls, one long hold-off while the sender runs
    initial begin
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                i_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                hold_long = 1'b0;
            end else begin
                wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
                if (wait_cycles > 0) begin
                    i_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [31:0] x, y;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: zeros, extremes, cancellation, wide alignment, range
        send_word(OpAdd, 32'h0000_0000, 32'h0000_0000);
        send_word(OpSub, 32'h3f80_0000, 32'h3f80_0000);
        send_word(OpAdd, 32'h3f80_0000, 32'hbf80_0000);
        send_word(OpAdd, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OpSub, 32'h7fff_ffff, 32'hffff_ffff);
        send_word(OpAdd, 32'h7f80_0000, 32'h7f80_0000);
        send_word(OpAdd, 32'h0000_0000, 32'h8000_0000);
        send_word(OpSub, 32'h0080_0000, 32'h0000_0001);
        send_word(OpAdd, 32'h4000_0000, 32'h3280_0000);
        send_word(OpAdd, 32'h4000_0000, 32'h3300_0000);
        send_word(OpAdd, 32'h3280_0000, 32'h4000_0000);
        send_word(OpSub, 32'h3fff_ffff, 32'h3fff_fffe);
        send_word(OpAdd, 32'h5555_5555, 32'haaaa_aaaa);
        send_word(OpSub, 32'haaaa_aaaa, 32'h5555_5555);
        send_word(OpAdd, 32'h7f7f_ffff, 32'h7f7f_ffff);
        send_word(OpSub, 32'h0000_0000, 32'h7fff_ffff);

        // Long receiver hold-off with the sender still offering words
        hold_long = 1'b1;
        for (int i = 0; i < 20; i++) begin
            i_valid <= 1'b1;
            i_op <= 1'($urandom);
            i_a <= rand_operand();
            i_b <= rand_operand();
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end

        // Random operands, with near-equal pairs to exercise cancellation
        for (int i = 0; i < RandomWords; i++) begin
            x = ($urandom_range(0, 9) == 0) ? $urandom : rand_operand();
            if ($urandom_range(0, 3) == 0) y = x ^ 32'($urandom_range(0, 7));
            else y = ($urandom_range(0, 9) == 0) ? $urandom : rand_operand();
            send_word(1'($urandom), x, y);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/fas_pkg.sv
rtl/float32_add_sub_truncating.sv
verif/float32_add_sub_truncating_checker.sv
verif/float32_add_sub_truncating_tb.sv
